@@ sv/sysex_frame_deframer_assert.svh @@
// Assertion macros shared by the deframer's checker.
`ifndef SYSEX_FRAME_DEFRAMER_ASSERT_SVH
`define SYSEX_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sfd_pkg.sv @@
// Shared types and constants of the sysex frame deframer.
package sfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 64;
  localparam int MAX_VALUES          = 30;
  localparam int BYTE_W              = 8;
  localparam int VCNT_W              = 5;
  // Store address width for the largest supported frame (128 bytes).
  localparam int ADDR_W_MAX          = 7;
  // Frame byte 0 is the start marker, byte 1 the command, pairs follow.
  localparam int CMD_ADDR            = 1;
  localparam int FIRST_PAIR_ADDR     = 2;
  localparam int QUEUE_DEPTH         = 4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;
  localparam logic [BYTE_W-1:0]    START_MARKER_RST = 8'd240;
  localparam logic [BYTE_W-1:0]    END_MARKER_RST   = 8'd247;

  // One queued store operation; close marks the end marker of a frame.
  typedef struct packed {
    logic                  close;
    logic [ADDR_W_MAX-1:0] addr;
    logic [BYTE_W-1:0]     data;
  } sfd_op_t;

  // One decoded result.
  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] value;
    logic [VCNT_W-1:0] value_index;
    logic [VCNT_W-1:0] value_count;
    logic              has_value;
    logic              last;
  } sfd_res_t;

endpackage

@@ sv/sysex_frame_deframer.sv @@
// Top level of the sysex frame deframer.
//
// Takes one received byte per transfer on in_*. Outside a frame every byte but
// the start marker is dropped; the start marker opens or restarts a frame, later
// bytes are stored, and the end marker closes it. Byte 1 is the command and the
// following bytes are LSB/MSB pairs, each decoded as (MSB*128+LSB) mod 256.
// Each value leaves as one transfer on out_* together with the command, its
// index and the frame's value count; the final one carries tlast. A frame with
// no values gives one transfer with tuser low. Once the store holds
// MAX_FRAME_BYTES bytes only a start marker is taken (the end marker is dropped
// too). Timing: the front accepts one byte per cycle while the four-entry
// operation queue has room; the back drains one stored byte per cycle while
// idle and, on a closing frame, runs two reads of the frame store and the
// result load for each value, or the result load alone for an empty frame,
// waiting while the sink stalls. No clearing pass is needed after reset.
// Write cfg_* only while the block is idle.
module sysex_frame_deframer #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration: index 0 start marker, index 1 end marker.
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata,
  // Received byte stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // Decoded values.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [7:0] command, [15:8] value,
                                                    // [20:16] value_index,
                                                    // [25:21] value_count, zero above
  output logic                          out_tuser,  // [0] has_value
  output logic                          out_tlast
);
  import sfd_pkg::*;

  logic     fq_valid, fq_ready, bq_valid, bq_ready;
  sfd_op_t  fq_op, bq_op;
  sfd_res_t res;

  // Classify incoming bytes and track the open frame.
  sfd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_op      (fq_op)
  );

  // Decouple byte intake from value emission.
  sfd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_op    (fq_op),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_op     (bq_op)
  );

  // Store bytes and decode pairs when a frame closes.
  sfd_back #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (bq_valid),
    .pop_ready (bq_ready),
    .pop_op    (bq_op),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result fields, command in the lowest bits.
  assign out_tdata = {6'b0, res.value_count, res.value_index, res.value, res.command};
  assign out_tuser = res.has_value;
  assign out_tlast = res.last;

endmodule

@@ sv/sfd_fifo.sv @@
// Short operation queue between the deframer front and back.
module sfd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  sfd_pkg::sfd_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sfd_pkg::sfd_op_t pop_op
);
  import sfd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  sfd_op_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign push_ready = (fill_r != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ sv/sfd_front.sv @@
// Front end: marker registers, frame tracking and byte classification.
module sfd_front #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sfd_pkg::BYTE_W-1:0]    in_tdata,
  output logic                          q_valid,
  input  logic                          q_ready,
  output sfd_pkg::sfd_op_t              q_op
);
  import sfd_pkg::*;

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int AW    = $clog2(MAX_FRAME_BYTES);

  logic [BYTE_W-1:0] start_marker_r, start_marker_nxt;
  logic [BYTE_W-1:0] end_marker_r, end_marker_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic              accept, is_start, is_end, full;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;
  assign is_start  = (in_tdata == start_marker_r);
  assign is_end    = (in_tdata == end_marker_r);
  assign full      = (frame_len_r == LEN_W'(MAX_FRAME_BYTES));

  // Store every byte of an open frame that is neither a restart nor past capacity.
  assign q_valid    = in_tvalid && in_frame_r && !full && !is_start;
  assign q_op.close = is_end;
  assign q_op.addr  = ADDR_W_MAX'(frame_len_r[AW-1:0]);
  assign q_op.data  = in_tdata;

  always_comb begin
    start_marker_nxt = start_marker_r;
    end_marker_nxt   = end_marker_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_MARKER: start_marker_nxt = cfg_wdata;
        REG_END_MARKER:   end_marker_nxt   = cfg_wdata;
        default:          start_marker_nxt = start_marker_r;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt  = in_frame_r;
    frame_len_nxt = frame_len_r;
    if (accept) begin
      if (is_start) begin
        in_frame_nxt  = 1'b1;
        frame_len_nxt = LEN_W'(1);
      end else if (in_frame_r && !full) begin
        if (is_end) begin
          in_frame_nxt  = 1'b0;
          frame_len_nxt = '0;
        end else begin
          frame_len_nxt = frame_len_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
      in_frame_r     <= 1'b0;
      frame_len_r    <= '0;
    end else begin
      start_marker_r <= start_marker_nxt;
      end_marker_r   <= end_marker_nxt;
      in_frame_r     <= in_frame_nxt;
      frame_len_r    <= frame_len_nxt;
    end
  end

endmodule

@@ sv/sfd_back.sv @@
// Back end: frame store, pair decoding and result register.
module sfd_back #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  sfd_pkg::sfd_op_t  pop_op,
  output logic              out_valid,
  input  logic              out_ready,
  output sfd_pkg::sfd_res_t out_res
);
  import sfd_pkg::*;

  localparam int AW = $clog2(MAX_FRAME_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RD_LSB = 4'b0010,
    ST_RD_MSB = 4'b0100,
    ST_FORM   = 4'b1000
  } st_t;

  logic [BYTE_W-1:0]     store_mem [MAX_FRAME_BYTES];
  logic [BYTE_W-1:0]     rd_data_r;
  st_t                   state_r, state_nxt;
  logic [BYTE_W-1:0]     cmd_r, cmd_nxt;
  logic [VCNT_W-1:0]     count_r, count_nxt;
  logic [VCNT_W-1:0]     idx_r, idx_nxt;
  logic [BYTE_W-1:0]     lsb_r, lsb_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sfd_res_t              res_r, res_nxt;
  logic                  mem_we, load_ok, is_last;
  logic [ADDR_W_MAX-1:0] pairs, lsb_addr, msb_addr;
  logic [VCNT_W-1:0]     close_count;
  logic [AW-1:0]         rd_addr;

  assign pop_ready = (state_r == ST_IDLE);
  assign mem_we    = pop_ready && pop_valid;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign load_ok   = !out_valid_r || out_ready;
  assign is_last   = ((idx_r + 1'b1) == count_r);

  // Pairs start after the command byte; the end marker is never read.
  always_comb begin
    pairs = '0;
    if (pop_op.addr >= ADDR_W_MAX'(FIRST_PAIR_ADDR)) begin
      pairs = (pop_op.addr - ADDR_W_MAX'(FIRST_PAIR_ADDR)) >> 1;
    end
    close_count = (pairs > ADDR_W_MAX'(MAX_VALUES)) ? VCNT_W'(MAX_VALUES)
                                                     : pairs[VCNT_W-1:0];
  end

  assign lsb_addr = ADDR_W_MAX'(FIRST_PAIR_ADDR) + ADDR_W_MAX'({idx_r, 1'b0});
  assign msb_addr = {lsb_addr[ADDR_W_MAX-1:1], 1'b1};
  // Hold the MSB address through FORM so the read data stays put under stall.
  assign rd_addr  = (state_r == ST_RD_LSB) ? lsb_addr[AW-1:0] : msb_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[pop_op.addr[AW-1:0]] <= pop_op.data;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    lsb_nxt       = lsb_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_op.addr == ADDR_W_MAX'(CMD_ADDR)) begin
            cmd_nxt = pop_op.data;
          end
          if (pop_op.close) begin
            count_nxt = close_count;
            idx_nxt   = '0;
            state_nxt = (close_count == '0) ? ST_FORM : ST_RD_LSB;
          end
        end
      end
      ST_RD_LSB: state_nxt = ST_RD_MSB;
      ST_RD_MSB: begin
        lsb_nxt   = rd_data_r;
        state_nxt = ST_FORM;
      end
      ST_FORM: begin
        if (load_ok) begin
          out_valid_nxt   = 1'b1;
          res_nxt.command = cmd_r;
          if (count_r == '0) begin
            res_nxt.value       = '0;
            res_nxt.value_index = '0;
            res_nxt.value_count = '0;
            res_nxt.has_value   = 1'b0;
            res_nxt.last        = 1'b1;
            state_nxt           = ST_IDLE;
          end else begin
            // MSB*128 only reaches bit 7 of the 8-bit result.
            res_nxt.value       = {lsb_r[7] ^ rd_data_r[0], lsb_r[6:0]};
            res_nxt.value_index = idx_r;
            res_nxt.value_count = count_r;
            res_nxt.has_value   = 1'b1;
            res_nxt.last        = is_last;
            idx_nxt             = idx_r + 1'b1;
            state_nxt           = is_last ? ST_IDLE : ST_RD_LSB;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    lsb_r   <= lsb_nxt;
    res_r   <= res_nxt;
  end

endmodule

@@ sv/sfd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
`include "sysex_frame_deframer_assert.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result holds its payload.
  `SFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // An empty frame reports one closing result with zeroed value fields.
  `SFD_ASSERT_NOW(a_empty_frame, out_tvalid && !out_tuser, out_tlast && (out_tdata[25:8] == 18'd0), "empty frame result malformed")

  // A value's index stays below the frame's value count.
  `SFD_ASSERT_NOW(a_index_range, out_tvalid && out_tuser, out_tdata[20:16] < out_tdata[25:21], "value index out of range")

  // tlast marks exactly the final value of a frame.
  `SFD_ASSERT_NOW(a_last_pos, out_tvalid && out_tuser, out_tlast == ((out_tdata[20:16] + 5'd1) == out_tdata[25:21]), "tlast misplaced")

endmodule

bind sysex_frame_deframer sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ sim/sysex_frame_deframer_test.sv @@
// Self-checking testbench for the sysex frame deframer: directed and random byte streams.
`timescale 1ns / 1ps

module sysex_frame_deframer_test;
  import sfd_pkg::*;

  localparam int MAX_FRAME     = MAX_FRAME_BYTES_DEF;
  // Bytes still in the operation queue when the last value has left: the
  // queue holds four, the back drains one per cycle. Allow plenty of margin.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_MARKER;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] command, [15:8] value, [20:16] value_index,
                                   // [25:21] value_count, zero above
  logic        out_tuser;          // [0] has_value
  logic        out_tlast;

  // Idle controls, changed per test phase (percent of cycles).
  int send_gap_pct = 0;
  int stall_pct    = 0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Decoded values the block still owes, oldest first.
  sfd_res_t pending_values[$];

  // Deframer state as the testbench sees it.
  logic [7:0] start_mark = START_MARKER_RST;
  logic [7:0] end_mark   = END_MARKER_RST;
  logic       frame_open = 1'b0;
  int         frame_len  = 0;
  logic [7:0] frame_buf [MAX_FRAME];

  sysex_frame_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Run watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sysex_frame_deframer_test: errors");
      $finish;
    end
  end

  // Sink side: stall at random according to the phase setting.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Track one accepted byte and queue the values the closing of a frame yields.
  function automatic void deframe_byte(input logic [7:0] b);
    int       n_vals;
    int       lsb;
    int       msb;
    sfd_res_t r;
    // Outside a frame, or with a full store, only a start marker gets through.
    if (!frame_open || frame_len >= MAX_FRAME) begin
      if (b == start_mark) begin
        frame_open   = 1'b1;
        frame_buf[0] = b;
        frame_len    = 1;
      end
      return;
    end
    // Start check wins over end check, so equal markers always restart.
    if (b == start_mark) begin
      frame_buf[0] = b;
      frame_len    = 1;
      return;
    end
    frame_buf[frame_len] = b;
    frame_len++;
    if (b != end_mark) return;

    // Frame closed: byte 1 is the command, pairs start at byte 2, and the
    // end marker itself never forms part of a pair.
    n_vals = (frame_len >= 3) ? (frame_len - 3) / 2 : 0;
    if (n_vals > MAX_VALUES) n_vals = MAX_VALUES;
    r = '0;
    r.command = frame_buf[CMD_ADDR];
    if (n_vals == 0) begin
      r.last = 1'b1;
      pending_values.push_back(r);
    end
    for (int k = 0; k < n_vals; k++) begin
      lsb = frame_buf[FIRST_PAIR_ADDR + 2 * k];
      msb = frame_buf[FIRST_PAIR_ADDR + 2 * k + 1];
      r.value       = BYTE_W'((msb * 128 + lsb) & 8'hFF);
      r.value_index = VCNT_W'(k);
      r.value_count = VCNT_W'(n_vals);
      r.has_value   = 1'b1;
      r.last        = (k + 1 == n_vals);
      pending_values.push_back(r);
    end
    frame_open = 1'b0;
    frame_len  = 0;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
               $realtime, field, want, want, got, got);
  endtask

  // Result checker: compare every transfer on out_* with the oldest expectation.
  always @(posedge clk) begin : check_values
    sfd_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        note_mismatch("unexpected transfer, tdata", 0, out_tdata);
      end else begin
        want = pending_values.pop_front();
        if (out_tdata[7:0] !== want.command)
          note_mismatch("command", want.command, out_tdata[7:0]);
        if (out_tdata[15:8] !== want.value)
          note_mismatch("value", want.value, out_tdata[15:8]);
        if (out_tdata[20:16] !== want.value_index)
          note_mismatch("value_index", want.value_index, out_tdata[20:16]);
        if (out_tdata[25:21] !== want.value_count)
          note_mismatch("value_count", want.value_count, out_tdata[25:21]);
        if (out_tdata[31:26] !== 6'd0)
          note_mismatch("tdata padding", 0, out_tdata[31:26]);
        if (out_tuser !== want.has_value)
          note_mismatch("has_value", want.has_value, out_tuser);
        if (out_tlast !== want.last)
          note_mismatch("last", want.last, out_tlast);
      end
    end
  end

  // Send one byte: optional idle gap first, then hold tvalid until the transfer.
  // tvalid stays high on return so back-to-back bytes need no bubble.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
  endtask

  // Drop tvalid, wait for every owed value, then let the queue run dry.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both marker registers; call only while the block is idle.
  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= REG_END_MARKER;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_mark = s;
    end_mark   = e;
  endtask

  // A data byte that is neither marker.
  function automatic logic [7:0] pick_data();
    logic [7:0] d;
    do d = 8'($urandom_range(0, 255)); while (d == start_mark || d == end_mark);
    return d;
  endfunction

  task automatic test_empty_frames();
    send_gap_pct = 0;
    stall_pct    = 0;
    // Command only, no data: one result with has_value low.
    send_byte(start_mark); send_byte(8'h10); send_byte(end_mark);
    // End marker right after the start is taken as the command.
    send_byte(start_mark); send_byte(end_mark);
    settle();
  endtask

  task automatic test_pair_decode();
    send_gap_pct = 0;
    stall_pct    = 0;
    send_byte(start_mark); send_byte(8'h55);
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h7F); send_byte(8'h7F);
    send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h01);                       // unpaired, must be ignored
    send_byte(end_mark);
    settle();
  endtask

  task automatic test_noise_and_restart();
    // Bytes outside a frame are dropped, end marker included.
    send_byte(8'h00); send_byte(8'hFF); send_byte(end_mark);
    // Second start marker throws away the partial frame.
    send_byte(start_mark); send_byte(8'h11); send_byte(8'h22);
    send_byte(start_mark); send_byte(8'h33); send_byte(8'h44); send_byte(8'h55);
    send_byte(end_mark);
    settle();
  endtask

  task automatic test_full_store();
    // Fill all 64 entries; the end marker that follows is dropped.
    send_byte(start_mark); send_byte(8'h21);
    repeat (MAX_FRAME - 2) send_byte(pick_data());
    send_byte(end_mark); send_byte(8'h10);
    // Only a start marker reopens the frame. Largest frame that still
    // closes: 30 values plus an odd byte.
    send_byte(start_mark); send_byte(8'h42);
    repeat (MAX_FRAME - 3) send_byte(pick_data());
    send_byte(end_mark);
    settle();
  endtask

  task automatic test_marker_extremes();
    set_markers(8'h00, 8'hFF);
    send_byte(8'h00); send_byte(8'hAB); send_byte(8'h80); send_byte(8'h01);
    send_byte(8'hFF);
    settle();
    set_markers(8'hFF, 8'h00);
    send_byte(8'hFF); send_byte(8'hCD); send_byte(8'h7F); send_byte(8'hFE);
    send_byte(8'h00);
    settle();
    // Equal markers: every marker restarts, so nothing ever closes.
    set_markers(8'h5A, 8'h5A);
    send_byte(8'h5A); send_byte(8'h01); send_byte(8'h5A); send_byte(8'h02);
    send_byte(8'h03); send_byte(8'h5A);
    settle();
    // Frame is still open from above; a distinct end marker now closes it.
    set_markers(8'h5A, 8'hA5);
    send_byte(8'h04); send_byte(8'h05); send_byte(8'hA5);
    settle();
  endtask

  // One random frame: mostly well formed, sometimes noise, a missing end,
  // an overfull store or a stray marker inside.
  task automatic send_random_frame(inout int sent);
    int kind;
    int n_data;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // Noise between frames, markers included now and then.
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 5))
          0:       send_byte(end_mark);
          1:       send_byte(start_mark);
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
        sent++;
      end
      return;
    end
    if (kind < 20) n_data = $urandom_range(MAX_FRAME - 6, MAX_FRAME);
    else           n_data = $urandom_range(0, 12);
    send_byte(start_mark);
    send_byte(($urandom_range(0, 9) == 0) ? end_mark : pick_data());
    sent += 2;
    for (int k = 0; k < n_data; k++) begin
      // Rare stray start marker restarts mid-frame.
      send_byte(($urandom_range(0, 99) == 0) ? start_mark : pick_data());
      sent++;
    end
    if ($urandom_range(0, 9) != 0) begin
      send_byte(end_mark);
      sent++;
    end
  endtask

  task automatic test_random_stream(input int gap_pct, input int stall, input bit keep_marks);
    int         sent;
    logic [7:0] s;
    logic [7:0] e;
    settle();
    if (keep_marks) begin
      s = START_MARKER_RST;
      e = END_MARKER_RST;
    end else begin
      s = 8'($urandom_range(0, 255));
      do e = 8'($urandom_range(0, 255)); while (e == s);
    end
    set_markers(s, e);
    send_gap_pct = gap_pct;
    stall_pct    = stall;
    sent = 0;
    while (sent < 6) send_random_frame(sent);
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_frames();
    test_pair_decode();
    test_noise_and_restart();
    test_full_store();
    test_marker_extremes();

    test_random_stream(0, 0, 1'b1);
    test_random_stream(78, 0, 1'b0);
    test_random_stream(0, 78, 1'b0);
    test_random_stream(25, 25, 1'b0);

    if (mismatch_count == 0 && pending_values.size() == 0) begin
      $display("sysex_frame_deframer_test: clean");
    end else begin
      $display("sysex_frame_deframer_test: errors");
    end
    $finish;
  end

endmodule
